// File: sv/greedy_text_line_wrapper_assert.svh
// Assertion macros shared by the line wrapper RTL.
`ifndef GREEDY_TEXT_LINE_WRAPPER_ASSERT_SVH
`define GREEDY_TEXT_LINE_WRAPPER_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet while rst is high.
`define GTLW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst is high.
`define GTLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gtlw_pkg.sv
// Types and constants shared by the greedy text line wrapper modules.
package gtlw_pkg;

  // Character kinds as carried on the input beat.
  typedef enum logic [2:0] {
    KIND_GLYPH           = 3'd0,
    KIND_SPACE           = 3'd1,
    KIND_LINE_FEED       = 3'd2,
    KIND_CARRIAGE_RETURN = 3'd3,
    KIND_END_OF_TEXT     = 3'd4
  } gtlw_kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FACTOR   = 2'd1;

  localparam logic [15:0] MAX_LINE_WIDTH_RESET = 16'd320;
  localparam logic [7:0]  SCALE_FACTOR_RESET   = 8'd1;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] char_kind;
    logic [7:0] glyph_width;
  } gtlw_in_t;

  typedef struct packed {
    logic [15:0] line_start;
    logic [15:0] line_length;
    logic [15:0] line_width;
  } gtlw_out_t;

  // Classified character with its scaled, saturated width.
  typedef struct packed {
    gtlw_kind_t kind;
    logic [7:0] char_width;
  } gtlw_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gtlw_qstat_t;

endpackage

// File: sv/gtlw_front.sv
// Front part: accepts characters, drops unused kinds and scales glyph widths.
module gtlw_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gtlw_pkg::gtlw_in_t   in_data,
  input  logic [7:0]           scale_factor,
  input  gtlw_pkg::gtlw_qstat_t q_stat,
  output logic                 fwd_valid,
  output gtlw_pkg::gtlw_op_t   fwd_op
);

  logic        take;
  logic        known_kind;
  logic [15:0] product;
  logic [7:0]  char_width;

  assign in_ready   = !fwd_valid || !q_stat.full;
  assign take       = in_valid && in_ready;
  assign known_kind = in_data.char_kind <= 3'(gtlw_pkg::KIND_END_OF_TEXT);
  assign product    = 16'(in_data.glyph_width) * 16'(scale_factor);
  assign char_width = (|product[15:8]) ? 8'hFF : product[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (take) begin
      // Kinds beyond end of text have no effect at all, so they stop here.
      fwd_valid <= known_kind;
    end else if (!q_stat.full) begin
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_op.kind       <= gtlw_pkg::gtlw_kind_t'(in_data.char_kind);
      fwd_op.char_width <= char_width;
    end
  end

endmodule

// File: sv/gtlw_queue.sv
// Small register queue between the front and back parts.
module gtlw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gtlw_pkg::gtlw_op_t    push_op,
  input  logic                  pop,
  output gtlw_pkg::gtlw_op_t    pop_op,
  output gtlw_pkg::gtlw_qstat_t stat
);

  gtlw_pkg::gtlw_op_t              slots [gtlw_pkg::QDEPTH];
  logic [gtlw_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [gtlw_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [gtlw_pkg::QPTR_BITS:0]    count;

  assign stat.full  = count == (gtlw_pkg::QPTR_BITS+1)'(gtlw_pkg::QDEPTH);
  assign stat.empty = count == '0;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// File: sv/gtlw_back.sv
// Back part: keeps the line state and forms one line segment per break.
module gtlw_back #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           max_line_width,
  input  gtlw_pkg::gtlw_qstat_t q_stat,
  input  gtlw_pkg::gtlw_op_t    q_op,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gtlw_pkg::gtlw_out_t   out_data
);

  logic [POS_BITS-1:0] position, position_next;
  logic [POS_BITS-1:0] line_begin, line_begin_next;
  logic [POS_BITS-1:0] space_position, space_position_next;
  logic                space_valid, space_valid_next;
  logic [7:0]          space_char_width, space_char_width_next;
  logic [15:0]         running_width, running_width_next;
  logic [15:0]         width_before_space, width_before_space_next;

  logic [POS_BITS-1:0] idx_inc;
  logic [POS_BITS-1:0] cur_len;
  logic [16:0]         run_plus;
  logic [15:0]         run_plus_sat;
  logic                overflow;
  logic [16:0]         used;
  logic [15:0]         rest;
  logic [16:0]         rest_plus;
  logic [15:0]         rest_plus_sat;
  logic                res_valid;
  gtlw_pkg::gtlw_out_t res;
  gtlw_pkg::gtlw_out_t cur_line;

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  assign idx_inc       = position + POS_BITS'(1);
  assign cur_len       = position - line_begin;
  assign run_plus      = {1'b0, running_width} + 17'(q_op.char_width);
  assign run_plus_sat  = run_plus[16] ? 16'hFFFF : run_plus[15:0];
  assign overflow      = run_plus > {1'b0, max_line_width};
  assign used          = {1'b0, width_before_space} + 17'(space_char_width);
  assign rest          = ({1'b0, running_width} > used) ?
                         16'({1'b0, running_width} - used) : 16'd0;
  assign rest_plus     = {1'b0, rest} + 17'(q_op.char_width);
  assign rest_plus_sat = rest_plus[16] ? 16'hFFFF : rest_plus[15:0];

  assign cur_line.line_start  = 16'(line_begin);
  assign cur_line.line_length = 16'(cur_len);
  assign cur_line.line_width  = running_width;

  always_comb begin
    position_next           = position;
    line_begin_next         = line_begin;
    space_position_next     = space_position;
    space_valid_next        = space_valid;
    space_char_width_next   = space_char_width;
    running_width_next      = running_width;
    width_before_space_next = width_before_space;
    res_valid               = 1'b0;
    res                     = '0;

    unique case (q_op.kind)
      gtlw_pkg::KIND_CARRIAGE_RETURN: begin
        position_next = idx_inc;
      end
      gtlw_pkg::KIND_END_OF_TEXT: begin
        res_valid               = running_width != '0;
        res                     = cur_line;
        position_next           = '0;
        line_begin_next         = '0;
        space_position_next     = '0;
        space_valid_next        = 1'b0;
        space_char_width_next   = '0;
        running_width_next      = '0;
        width_before_space_next = '0;
      end
      gtlw_pkg::KIND_LINE_FEED: begin
        res_valid               = 1'b1;
        res                     = (running_width != '0) ? cur_line : '0;
        line_begin_next         = idx_inc;
        space_position_next     = '0;
        space_valid_next        = 1'b0;
        width_before_space_next = '0;
        running_width_next      = '0;
        position_next           = idx_inc;
      end
      gtlw_pkg::KIND_GLYPH, gtlw_pkg::KIND_SPACE: begin
        position_next = idx_inc;
        if (overflow) begin
          space_position_next     = '0;
          space_valid_next        = 1'b0;
          width_before_space_next = '0;
          priority if (q_op.kind == gtlw_pkg::KIND_SPACE) begin
            // An overflowing space ends the line and is swallowed.
            res_valid          = running_width != '0;
            res                = cur_line;
            line_begin_next    = idx_inc;
            running_width_next = '0;
          end else if (space_valid) begin
            // Break back at the last inner space; the word moves down.
            res_valid            = width_before_space != '0;
            res.line_start       = 16'(line_begin);
            res.line_length      = 16'(space_position - line_begin);
            res.line_width       = width_before_space;
            line_begin_next      = space_position + POS_BITS'(1);
            running_width_next   = rest_plus_sat;
          end else begin
            // No inner space: cut the word at this character.
            res_valid          = running_width != '0;
            res                = cur_line;
            line_begin_next    = position;
            running_width_next = 16'(q_op.char_width);
          end
        end else if (q_op.kind == gtlw_pkg::KIND_SPACE) begin
          if (running_width != '0) begin
            space_position_next     = position;
            space_valid_next        = 1'b1;
            width_before_space_next = running_width;
            running_width_next      = run_plus_sat;
            space_char_width_next   = q_op.char_width;
          end else begin
            // Leading spaces are dropped from the line.
            line_begin_next         = idx_inc;
            space_position_next     = '0;
            space_valid_next        = 1'b0;
            width_before_space_next = '0;
            running_width_next      = '0;
          end
        end else begin
          running_width_next = run_plus_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      line_begin         <= '0;
      space_position     <= '0;
      space_valid        <= 1'b0;
      space_char_width   <= '0;
      running_width      <= '0;
      width_before_space <= '0;
    end else if (pop) begin
      position           <= position_next;
      line_begin         <= line_begin_next;
      space_position     <= space_position_next;
      space_valid        <= space_valid_next;
      space_char_width   <= space_char_width_next;
      running_width      <= running_width_next;
      width_before_space <= width_before_space_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// File: sv/greedy_text_line_wrapper.sv
// Top level of the greedy text line wrapper: config registers and part wiring.
//
//   Channel  Direction  Handshake              Beat contents
//   in       input      in_valid / in_ready    char_kind, glyph_width
//   out      output     out_valid / out_ready  line_start, line_length, line_width
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One character is taken per cycle unless a full queue stalls the front; the back
// part updates the running position and widths with combinational adds and
// compares. A line passes the front register, a queue slot and the output
// register before it is valid on out.
// Reset clears all line state and loads max_line_width 320 and scale_factor 1.
// Front and back stall on their own: the four-entry queue absorbs a stalled out.
`include "greedy_text_line_wrapper_assert.svh"

module greedy_text_line_wrapper #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  gtlw_pkg::gtlw_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output gtlw_pkg::gtlw_out_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gtlw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [15:0]                            cfg_data
);

  // Configuration registers. Writes must arrive only while the block is idle
  // (the user's duty; the block does not enforce it), so both parts read them directly.
  logic [15:0] max_line_width;
  logic [7:0]  scale_factor;

  logic                  fwd_valid;
  gtlw_pkg::gtlw_op_t    fwd_op;
  gtlw_pkg::gtlw_qstat_t q_stat;
  gtlw_pkg::gtlw_op_t    q_op;
  logic                  q_push;
  logic                  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_width <= gtlw_pkg::MAX_LINE_WIDTH_RESET;
      scale_factor   <= gtlw_pkg::SCALE_FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the register list are accepted and ignored.
      if (cfg_index == gtlw_pkg::REG_MAX_LINE_WIDTH) begin
        max_line_width <= cfg_data;
      end
      if (cfg_index == gtlw_pkg::REG_SCALE_FACTOR) begin
        scale_factor <= cfg_data[7:0];
      end
    end
  end

  // The front part classifies each character and scales its width once, so the
  // back part sees only the kinds that matter and a ready-made 8-bit width.
  gtlw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .scale_factor (scale_factor),
    .q_stat       (q_stat),
    .fwd_valid    (fwd_valid),
    .fwd_op       (fwd_op)
  );

  assign q_push = fwd_valid && !q_stat.full;

  gtlw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (fwd_op),
    .pop     (q_pop),
    .pop_op  (q_op),
    .stat    (q_stat)
  );

  // The back part pops one character whenever its output register is free or
  // being emptied, and writes a line into that register when one ends.
  gtlw_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .max_line_width (max_line_width),
    .q_stat         (q_stat),
    .q_op           (q_op),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // The queue can never report full and empty at once.
  `GTLW_ASSERT_IMPL(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")

  // A classified character waiting on a full queue is held, not lost.
  `GTLW_ASSERT_NEXT(a_front_hold, fwd_valid && q_stat.full, fwd_valid && $stable(fwd_op), "front dropped")

  // A queued character stays queued until the back part pops it.
  `GTLW_ASSERT_NEXT(a_queue_keep, !q_stat.empty && !q_pop, !q_stat.empty, "queue lost an entry")

  // Every line feed that the back part takes yields a line segment.
  `GTLW_ASSERT_NEXT(a_lf_emits, q_pop && q_op.kind == gtlw_pkg::KIND_LINE_FEED, out_valid, "line feed lost")

endmodule
